// ===== sv/ofb_pkg.sv =====
// shared types and constants of the overlap feather blend core
`timescale 1ns / 1ps

package ofb_pkg;

	// register reset values and field widths
	localparam int COL_W          = 12;
	localparam int WIDTH_W        = 13;
	localparam int CH_W           = 8;
	localparam int NUM_W          = WIDTH_W + CH_W;
	localparam int DEF_MAX_COLUMNS = 4096;

	localparam logic [COL_W-1:0]   RST_OVERLAP_START = 12'd0;
	localparam logic [WIDTH_W-1:0] RST_LEFT_WIDTH    = 13'd4096;
	localparam logic [CH_W-1:0]    RST_DARK_LEVEL    = 8'd50;

	// register indexes of the configuration port
	localparam logic [1:0] REG_OVERLAP_START = 2'd0;
	localparam logic [1:0] REG_LEFT_WIDTH    = 2'd1;
	localparam logic [1:0] REG_DARK_LEVEL    = 2'd2;

	// pipeline depths: one product stage and one stage per quotient bit
	localparam int LANE_LAT  = 1 + CH_W;
	localparam int TOTAL_LAT = 1 + LANE_LAT + 1;

	typedef enum logic [1:0] {
		SEL_LEFT,
		SEL_WARPED,
		SEL_BLEND
	} sel_t;

	typedef struct packed {
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] r;
	} pix_t;

	// decoded word leaving the front stage
	typedef struct packed {
		logic               valid;
		sel_t               sel;
		logic [WIDTH_W-1:0] n;
		logic [COL_W-1:0]   m;
		logic [WIDTH_W-1:0] span;
		pix_t               left;
		pix_t               warped;
	} front_t;

	// control carried alongside the lanes
	typedef struct packed {
		sel_t sel;
		pix_t left;
		pix_t warped;
	} merge_ctrl_t;

endpackage

// ===== sv/ofb_front.sv =====
// front stage: region decode, dark test and ramp weights
`timescale 1ns / 1ps

module ofb_front #(
	parameter int MAX_COLUMNS = ofb_pkg::DEF_MAX_COLUMNS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [ofb_pkg::COL_W-1:0]    overlap_start,
	input  logic [ofb_pkg::WIDTH_W-1:0]  left_width,
	input  logic [ofb_pkg::CH_W-1:0]     dark_level,
	input  logic [ofb_pkg::COL_W-1:0]    column,
	input  ofb_pkg::pix_t                left,
	input  ofb_pkg::pix_t                warped,
	output ofb_pkg::front_t              item_s1
);

	localparam int CMP_W = 18;

	logic [ofb_pkg::WIDTH_W-1:0] width;
	logic                        before_start;
	logic                        past_width;
	logic                        dark;
	ofb_pkg::sel_t               sel;

	// saturate the width to the column limit
	always_comb begin
		if (CMP_W'(left_width) > CMP_W'(MAX_COLUMNS)) begin
			width = ofb_pkg::WIDTH_W'(MAX_COLUMNS);
		end else begin
			width = left_width;
		end
	end

	// region decode
	assign before_start = column < overlap_start;
	assign past_width   = {1'b0, column} >= width;
	assign dark         = (warped.b < dark_level) && (warped.g < dark_level) &&
		(warped.r < dark_level);

	always_comb begin
		if (before_start) begin
			sel = ofb_pkg::SEL_LEFT;
		end else if (past_width) begin
			sel = ofb_pkg::SEL_WARPED;
		end else if (dark) begin
			sel = ofb_pkg::SEL_LEFT;
		end else begin
			sel = ofb_pkg::SEL_BLEND;
		end
	end

	// valid flag and payload: left weight n = width - column, warped weight m = column - start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid  <= accept;
			item_s1.sel    <= sel;
			item_s1.n      <= width - {1'b0, column};
			item_s1.m      <= column - overlap_start;
			item_s1.span   <= width - {1'b0, overlap_start};
			item_s1.left   <= left;
			item_s1.warped <= warped;
		end
	end

endmodule

// ===== sv/ofb_lane.sv =====
// one colour lane: weighted sum then pipelined restoring divide by the span
`timescale 1ns / 1ps

module ofb_lane (
	input  logic                        clk,
	input  logic [ofb_pkg::CH_W-1:0]    l,
	input  logic [ofb_pkg::CH_W-1:0]    w,
	input  logic [ofb_pkg::WIDTH_W-1:0] n,
	input  logic [ofb_pkg::COL_W-1:0]   m,
	input  logic [ofb_pkg::WIDTH_W-1:0] span,
	output logic [ofb_pkg::CH_W-1:0]    quot
);

	localparam int NW = ofb_pkg::NUM_W;
	localparam int QW = ofb_pkg::CH_W;

	logic [NW-1:0]               prod_l;
	logic [NW-1:0]               prod_w;
	logic [NW-1:0]               rem_s    [0:QW];
	logic [QW-1:0]               quo_s    [0:QW];
	logic [ofb_pkg::WIDTH_W-1:0] divisor_s [0:QW];

	// weighted sum, at most 255 times the span
	assign prod_l = NW'(l) * NW'(n);
	assign prod_w = NW'(w) * NW'(m);

	always_ff @(posedge clk) begin
		rem_s[0]     <= prod_l + prod_w;
		quo_s[0]     <= '0;
		divisor_s[0] <= span;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW-1:0] trial;
		logic          fits;

		assign trial = NW'(divisor_s[k]) << (QW - 1 - k);
		assign fits  = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			rem_s[k+1]     <= fits ? (rem_s[k] - trial) : rem_s[k];
			quo_s[k+1]     <= {quo_s[k][QW-2:0], fits};
			divisor_s[k+1] <= divisor_s[k];
		end
	end

	assign quot = quo_s[QW];

endmodule

// ===== sv/ofb_merge.sv =====
// merge stage: control delay line and final per-channel selection
`timescale 1ns / 1ps

module ofb_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ofb_pkg::front_t          item_s1,
	input  ofb_pkg::pix_t            blend,
	output logic                     done,
	output ofb_pkg::pix_t            pix
);

	localparam int DEPTH = ofb_pkg::LANE_LAT;

	logic                 valid_q [0:DEPTH-1];
	ofb_pkg::merge_ctrl_t ctrl_q  [0:DEPTH-1];
	ofb_pkg::merge_ctrl_t tail;
	ofb_pkg::pix_t        pick;
	logic                 done_q;
	ofb_pkg::pix_t        pix_q;

	// valid bits follow the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			valid_q[0] <= item_s1.valid;
			for (int i = 1; i < DEPTH; i++) begin
				valid_q[i] <= valid_q[i-1];
			end
			done_q <= valid_q[DEPTH-1];
		end
	end

	// selection and pass-through pixels follow the lanes
	always_ff @(posedge clk) begin
		ctrl_q[0] <= '{sel: item_s1.sel, left: item_s1.left, warped: item_s1.warped};
		for (int i = 1; i < DEPTH; i++) begin
			ctrl_q[i] <= ctrl_q[i-1];
		end
	end

	assign tail = ctrl_q[DEPTH-1];

	// choose the composed word
	always_comb begin
		case (tail.sel)
			ofb_pkg::SEL_LEFT:   pick = tail.left;
			ofb_pkg::SEL_WARPED: pick = tail.warped;
			ofb_pkg::SEL_BLEND:  pick = blend;
			default:             pick = tail.left;
		endcase
	end

	always_ff @(posedge clk) begin
		pix_q <= pick;
	end

	assign done = done_q;
	assign pix  = pix_q;

endmodule

// ===== sv/overlap_feather_blend_core.sv =====
// top level of the overlap feather blend core
`timescale 1ns / 1ps

// Composes one pixel of a stitched row per word. A word is taken at every
// clock edge where start is high; busy is always low, so a new word may
// follow every cycle. Each result appears on out_blue/out_green/out_red for
// one cycle with done high, after passing through one decode stage, one
// weighted-sum stage, eight divider stages (one quotient bit each, three
// lanes in parallel, one per colour) and an output register. The receiver
// cannot stall; a result not taken in its cycle is gone.
// Configuration is written through cfg_we/cfg_index/cfg_data with the core
// idle; index 0 is overlap_start, 1 left_width, 2 dark_level, others ignored.

module overlap_feather_blend_core #(
	parameter int MAX_COLUMNS = ofb_pkg::DEF_MAX_COLUMNS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ofb_pkg::COL_W-1:0]   column,
	input  logic [ofb_pkg::CH_W-1:0]    left_blue,
	input  logic [ofb_pkg::CH_W-1:0]    left_green,
	input  logic [ofb_pkg::CH_W-1:0]    left_red,
	input  logic [ofb_pkg::CH_W-1:0]    warped_blue,
	input  logic [ofb_pkg::CH_W-1:0]    warped_green,
	input  logic [ofb_pkg::CH_W-1:0]    warped_red,
	output logic                        done,
	output logic [ofb_pkg::CH_W-1:0]    out_blue,
	output logic [ofb_pkg::CH_W-1:0]    out_green,
	output logic [ofb_pkg::CH_W-1:0]    out_red,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ofb_pkg::WIDTH_W-1:0] cfg_data
);

	logic [ofb_pkg::COL_W-1:0]   overlap_start_q;
	logic [ofb_pkg::WIDTH_W-1:0] left_width_q;
	logic [ofb_pkg::CH_W-1:0]    dark_level_q;
	logic                        accept;
	ofb_pkg::front_t             item_s1;
	ofb_pkg::pix_t               blend;
	ofb_pkg::pix_t               pix;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_start_q <= ofb_pkg::RST_OVERLAP_START;
			left_width_q    <= ofb_pkg::RST_LEFT_WIDTH;
			dark_level_q    <= ofb_pkg::RST_DARK_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				ofb_pkg::REG_OVERLAP_START: overlap_start_q <= cfg_data[ofb_pkg::COL_W-1:0];
				ofb_pkg::REG_LEFT_WIDTH:    left_width_q    <= cfg_data;
				ofb_pkg::REG_DARK_LEVEL:    dark_level_q    <= cfg_data[ofb_pkg::CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// decode
	ofb_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.overlap_start(overlap_start_q),
		.left_width   (left_width_q),
		.dark_level   (dark_level_q),
		.column       (column),
		.left         ({left_blue, left_green, left_red}),
		.warped       ({warped_blue, warped_green, warped_red}),
		.item_s1      (item_s1)
	);

	// colour lanes
	ofb_lane u_lane_b (
		.clk (clk),
		.l   (item_s1.left.b),
		.w   (item_s1.warped.b),
		.n   (item_s1.n),
		.m   (item_s1.m),
		.span(item_s1.span),
		.quot(blend.b)
	);

	ofb_lane u_lane_g (
		.clk (clk),
		.l   (item_s1.left.g),
		.w   (item_s1.warped.g),
		.n   (item_s1.n),
		.m   (item_s1.m),
		.span(item_s1.span),
		.quot(blend.g)
	);

	ofb_lane u_lane_r (
		.clk (clk),
		.l   (item_s1.left.r),
		.w   (item_s1.warped.r),
		.n   (item_s1.n),
		.m   (item_s1.m),
		.span(item_s1.span),
		.quot(blend.r)
	);

	// merge
	ofb_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.item_s1(item_s1),
		.blend  (blend),
		.done   (done),
		.pix    (pix)
	);

	assign out_blue  = pix.b;
	assign out_green = pix.g;
	assign out_red   = pix.r;

	// every result strobe traces back to an earlier accepted word
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, ofb_pkg::TOTAL_LAT))
		else $error("result strobe without a matching word");

	// columns before the overlap give the left pixel
	a_left_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (column < overlap_start_q) |-> ##(ofb_pkg::TOTAL_LAT)
		(done && out_blue == $past(left_blue, ofb_pkg::TOTAL_LAT) &&
		out_red == $past(left_red, ofb_pkg::TOTAL_LAT)))
		else $error("left region pixel altered");

	// columns past the left image give the warped pixel
	a_warped_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (column >= overlap_start_q) && ({1'b0, column} >= left_width_q)
		|-> ##(ofb_pkg::TOTAL_LAT)
		(done && out_green == $past(warped_green, ofb_pkg::TOTAL_LAT)))
		else $error("warped region pixel altered");

endmodule

// ===== bench/tb_overlap_feather_blend_core.sv =====
// self-checking testbench of the overlap feather blend core
`timescale 1ns / 1ps

module tb_overlap_feather_blend_core;

	localparam int MAX_COLS = ofb_pkg::DEF_MAX_COLUMNS;
	// index beyond the register map, writes must be ignored
	localparam logic [1:0] REG_SPARE = 2'd3;

	// predicts each composed pixel and checks the stream of results
	class blend_checker;
		logic [ofb_pkg::COL_W-1:0]   ovl_start;
		logic [ofb_pkg::WIDTH_W-1:0] left_w;
		logic [ofb_pkg::CH_W-1:0]    dark;
		ofb_pkg::pix_t               expected_q[$];
		int                          mismatches;

		function new();
			ovl_start  = ofb_pkg::RST_OVERLAP_START;
			left_w     = ofb_pkg::RST_LEFT_WIDTH;
			dark       = ofb_pkg::RST_DARK_LEVEL;
			mismatches = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [ofb_pkg::WIDTH_W-1:0] data);
			case (idx)
				ofb_pkg::REG_OVERLAP_START: ovl_start = data[ofb_pkg::COL_W-1:0];
				ofb_pkg::REG_LEFT_WIDTH:    left_w = data;
				ofb_pkg::REG_DARK_LEVEL:    dark = data[ofb_pkg::CH_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// truncated linear ramp of one channel
		function logic [ofb_pkg::CH_W-1:0] mix(int l, int w, int n, int span);
			int v;
			v = (l * n + w * (span - n)) / span;
			return v[ofb_pkg::CH_W-1:0];
		endfunction

		// note an accepted word and queue the pixel it must give
		function void note_word(logic [ofb_pkg::COL_W-1:0] col, ofb_pkg::pix_t lft,
			ofb_pkg::pix_t wrp);
			int            wid;
			int            span;
			int            n;
			ofb_pkg::sel_t route;
			ofb_pkg::pix_t res;
			wid = (int'(left_w) > MAX_COLS) ? MAX_COLS : int'(left_w);
			if (col < ovl_start)
				route = ofb_pkg::SEL_LEFT;
			else if (int'(col) >= wid)
				route = ofb_pkg::SEL_WARPED;
			else if (wrp.b < dark && wrp.g < dark && wrp.r < dark)
				route = ofb_pkg::SEL_LEFT;
			else
				route = ofb_pkg::SEL_BLEND;
			case (route)
				ofb_pkg::SEL_LEFT:   res = lft;
				ofb_pkg::SEL_WARPED: res = wrp;
				default: begin
					span  = wid - int'(ovl_start);
					n     = wid - int'(col);
					res.b = mix(int'(lft.b), int'(wrp.b), n, span);
					res.g = mix(int'(lft.g), int'(wrp.g), n, span);
					res.r = mix(int'(lft.r), int'(wrp.r), n, span);
				end
			endcase
			expected_q = {expected_q, res};
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			mismatches++;
		endtask

		// compare a result word with the oldest expectation
		task check_result(ofb_pkg::pix_t got);
			ofb_pkg::pix_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("pixel %h with none expected", got));
			end else begin
				want = expected_q.pop_front();
				if (got.b !== want.b)
					report($sformatf("out_blue %h, expected %h", got.b, want.b));
				if (got.g !== want.g)
					report($sformatf("out_green %h, expected %h", got.g, want.g));
				if (got.r !== want.r)
					report($sformatf("out_red %h, expected %h", got.r, want.r));
			end
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [ofb_pkg::COL_W-1:0]   column;
	logic [ofb_pkg::CH_W-1:0]    left_blue, left_green, left_red;
	logic [ofb_pkg::CH_W-1:0]    warped_blue, warped_green, warped_red;
	logic                        done;
	logic [ofb_pkg::CH_W-1:0]    out_blue, out_green, out_red;
	logic                        cfg_we;
	logic [1:0]                  cfg_index;
	logic [ofb_pkg::WIDTH_W-1:0] cfg_data;

	blend_checker sb = new();
	int cur_start;
	int cur_width;
	int rand_items;

	overlap_feather_blend_core #(.MAX_COLUMNS(MAX_COLS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.column(column), .left_blue(left_blue), .left_green(left_green),
		.left_red(left_red), .warped_blue(warped_blue), .warped_green(warped_green),
		.warped_red(warped_red), .done(done), .out_blue(out_blue),
		.out_green(out_green), .out_red(out_red), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result({out_blue, out_green, out_red});
			if (start && !busy)
				sb.note_word(column, {left_blue, left_green, left_red},
					{warped_blue, warped_green, warped_red});
		end
	end

	// offer one word from a falling edge and hold it until taken
	task automatic send_pixel(input logic [ofb_pkg::COL_W-1:0] col, input ofb_pkg::pix_t lft,
		input ofb_pkg::pix_t wrp);
		start        <= 1'b1;
		column       <= col;
		left_blue    <= lft.b;
		left_green   <= lft.g;
		left_red     <= lft.r;
		warped_blue  <= wrp.b;
		warped_green <= wrp.g;
		warped_red   <= wrp.r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random gap on the sender side, skipped over one long stretch
	task automatic maybe_idle();
		if (!(rand_items >= 250 && rand_items < 420) && $urandom_range(99, 0) < 21) begin
			start  <= 1'b0;
			column <= ofb_pkg::COL_W'($urandom);
			repeat ($urandom_range(4, 1))
				@(negedge clk);
		end
	endtask

	// stop sending until every expected pixel is back
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [ofb_pkg::WIDTH_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_register(idx, data);
		@(negedge clk);
	endtask

	// reprogram all registers with the core idle; unused upper bits get noise
	task automatic apply_config(input int s, input int w, input int dk);
		logic [ofb_pkg::WIDTH_W-1:0] d;
		drain();
		repeat (ofb_pkg::TOTAL_LAT)
			@(negedge clk);
		d = ofb_pkg::WIDTH_W'($urandom);
		d[ofb_pkg::COL_W-1:0] = ofb_pkg::COL_W'(s);
		write_reg(ofb_pkg::REG_OVERLAP_START, d);
		write_reg(ofb_pkg::REG_LEFT_WIDTH, ofb_pkg::WIDTH_W'(w));
		d = ofb_pkg::WIDTH_W'($urandom);
		d[ofb_pkg::CH_W-1:0] = ofb_pkg::CH_W'(dk);
		write_reg(ofb_pkg::REG_DARK_LEVEL, d);
		write_reg(REG_SPARE, ofb_pkg::WIDTH_W'($urandom));
		cfg_we    <= 1'b0;
		cur_start = s;
		cur_width = w;
	endtask

	// mostly inside the feather region, some on either side, some anywhere
	function automatic logic [ofb_pkg::COL_W-1:0] pick_column();
		int wid;
		int r;
		wid = (cur_width > MAX_COLS) ? MAX_COLS : cur_width;
		r = $urandom_range(99, 0);
		if (r < 70 && wid > cur_start)
			return ofb_pkg::COL_W'($urandom_range(wid - 1, cur_start));
		else if (r < 80 && cur_start > 0)
			return ofb_pkg::COL_W'($urandom_range(cur_start - 1, 0));
		else if (r < 90 && wid < MAX_COLS)
			return ofb_pkg::COL_W'($urandom_range(MAX_COLS - 1, wid));
		return ofb_pkg::COL_W'($urandom);
	endfunction

	// warped pixels: dark ones, ones on the dark threshold, and arbitrary ones
	function automatic ofb_pkg::pix_t pick_warped(input int dk);
		ofb_pkg::pix_t p;
		int            r;
		p = 24'($urandom);
		r = $urandom_range(9, 0);
		if (r < 3 && dk > 0) begin
			p.b = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
			p.g = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
			p.r = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
		end else if (r == 3 && dk > 0) begin
			p.b = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
			p.g = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
			p.r = ofb_pkg::CH_W'($urandom_range(dk - 1, 0));
			case ($urandom_range(2, 0))
				0: p.b = ofb_pkg::CH_W'(dk);
				1: p.g = ofb_pkg::CH_W'(dk);
				default: p.r = ofb_pkg::CH_W'(dk);
			endcase
		end
		return p;
	endfunction

	task automatic run_phase(input int s, input int w, input int dk, input int count);
		apply_config(s, w, dk);
		for (int i = 0; i < count; i++) begin
			// one hold-off until the pipeline is empty
			if (rand_items == 100)
				drain();
			send_pixel(pick_column(), 24'($urandom), pick_warped(dk));
			rand_items++;
			maybe_idle();
		end
	endtask

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_overlap_feather_blend_core NOT OK");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		column       = '0;
		left_blue    = '0;
		left_green   = '0;
		left_red     = '0;
		warped_blue  = '0;
		warped_green = '0;
		warped_red   = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cur_start    = int'(ofb_pkg::RST_OVERLAP_START);
		cur_width    = int'(ofb_pkg::RST_LEFT_WIDTH);
		rand_items   = 0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: whole row blends, dark level 50
		send_pixel(12'd0, 24'hffffff, 24'h808080);
		send_pixel(12'd4095, 24'h000000, 24'hffffff);
		send_pixel(12'd2048, 24'hffffff, 24'h000000);
		send_pixel(12'd2048, 24'h000000, 24'h320000);
		maybe_idle();

		// narrow overlap: both edges, dark warped inside and past the overlap
		apply_config(100, 356, 50);
		send_pixel(12'd99, 24'h123456, 24'hffffff);
		send_pixel(12'd100, 24'hffffff, 24'h000000);
		send_pixel(12'd355, 24'hff00ff, 24'h00ff00);
		send_pixel(12'd356, 24'hffffff, 24'h0a0b0c);
		send_pixel(12'd4095, 24'hffffff, 24'h000000);
		send_pixel(12'd200, 24'hffffff, 24'h313131);
		send_pixel(12'd200, 24'hffffff, 24'h313132);
		send_pixel(12'd0, 24'h000000, 24'hffffff);
		send_pixel(12'd228, 24'hffffff, 24'h000000);

		// width above the column limit is saturated, one-column overlap
		apply_config(4095, 8191, 255);
		send_pixel(12'd4095, 24'h00ff00, 24'hffffff);
		send_pixel(12'd4094, 24'h55aa55, 24'hffffff);

		// start past the width: nothing blends
		apply_config(200, 100, 0);
		send_pixel(12'd150, 24'h010203, 24'hfefdfc);
		send_pixel(12'd200, 24'h010203, 24'hfefdfc);
		send_pixel(12'd99, 24'h010203, 24'hfefdfc);

		// zero width
		apply_config(10, 0, 20);
		send_pixel(12'd5, 24'h112233, 24'h445566);
		send_pixel(12'd10, 24'h112233, 24'h445566);
		send_pixel(12'd0, 24'h112233, 24'h000000);

		// random words under fixed extreme settings, then random settings
		run_phase(100, 356, 50, 60);
		run_phase(0, 4096, 0, 60);
		run_phase(4095, 8191, 255, 60);
		run_phase(200, 100, 0, 60);
		run_phase(10, 0, 20, 60);
		run_phase(0, 1, 255, 60);
		repeat (5) begin
			int s;
			int w;
			s = ($urandom_range(1, 0) == 0) ? $urandom_range(300, 0) : $urandom_range(4095, 0);
			w = ($urandom_range(9, 0) < 7) ? s + $urandom_range(600, 1) : $urandom_range(8191, 0);
			run_phase(s, w, $urandom_range(255, 0), 70);
		end

		drain();
		repeat (ofb_pkg::TOTAL_LAT + 4)
			@(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_overlap_feather_blend_core OK");
		else
			$display("tb_overlap_feather_blend_core NOT OK");
		$finish;
	end

endmodule
